[rtl/mbcd_pkg.sv]
// ----------------------------------------------------------------------------
// mbcd_pkg: shared types and constants of the blob centroid detector
// Accumulator widths, register map, register reset values and the defaults
// of the frame size parameters.
// ----------------------------------------------------------------------------
package mbcd_pkg;

    // accumulator and count widths
    localparam int CNT_W = 19;
    localparam int SUM_W = 28;

    // default frame size
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    // configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_START_ROW  = 2'd0,
        REG_COUNT_LOW  = 2'd1,
        REG_COUNT_HIGH = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    // register reset values
    localparam int          START_ROW_RST  = 240;
    localparam logic [18:0] COUNT_LOW_RST  = 19'd1000;
    localparam logic [18:0] COUNT_HIGH_RST = 19'd4500;

endpackage

[rtl/masked_blob_centroid_detect.sv]
// ----------------------------------------------------------------------------
// masked_blob_centroid_detect: foreground pixel centroid over a frame
// Counts foreground pixels below a start row and sums their coordinates. On
// the frame end pixel, if the count lies strictly between the limits, a
// shared restoring divider divides both sums by it for the truncated centroid.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  pixel     in         i_in_valid / o_in_stall   i_col, i_row, i_foreground,
//                                                 i_frame_end
//  result    out        o_out_valid / i_out_stall o_detected, o_centroid_col,
//                                                 o_centroid_row, o_pixel_count
//  config    in         APB psel/penable/pwrite   start_row, count_low,
//                                                 count_high at 0x0, 0x4, 0x8
//
//  A pixel that does not end a frame is taken without stalling the input.
//  A frame end pixel stalls the input: without detection it goes straight
//  to loading; with it the single 1-bit-per-cycle divider runs 28 steps for
//  the column sum, then 28 for the row sum. It then waits until the output
//  register is free. Reset is synchronous, active low, and clears the
//  accumulators, the registers to their defaults and the output valid.
// ----------------------------------------------------------------------------
module masked_blob_centroid_detect #(
    parameter int FRAME_WIDTH  = mbcd_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mbcd_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [$clog2(FRAME_WIDTH)-1:0]    i_col,
    input  logic [$clog2(FRAME_HEIGHT)-1:0]   i_row,
    input  logic                              i_foreground,
    input  logic                              i_frame_end,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_detected,
    output logic [$clog2(FRAME_WIDTH)-1:0]    o_centroid_col,
    output logic [$clog2(FRAME_HEIGHT)-1:0]   o_centroid_row,
    output logic [mbcd_pkg::CNT_W-1:0]        o_pixel_count,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbcd_pkg::ADDR_W-1:0]       paddr,
    input  logic [mbcd_pkg::DATA_W-1:0]       pwdata,
    output logic [mbcd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int CNT_W  = mbcd_pkg::CNT_W;
    localparam int SUM_W  = mbcd_pkg::SUM_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int DATA_W = mbcd_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_DIV_COL = 4'b0010,
        S_DIV_ROW = 4'b0100,
        S_LOAD    = 4'b1000
    } t_state;

    t_state                 r_state;

    // configuration registers
    logic [ROW_W-1:0]       r_start_row;
    logic [CNT_W-1:0]       r_count_low;
    logic [CNT_W-1:0]       r_count_high;

    // accumulators
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_col_sum;
    logic [SUM_W-1:0]       r_row_sum;

    // divider
    logic [CNT_W-1:0]       r_div;
    logic [CNT_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [SUM_W-1:0]       r_row_dvd;
    logic [STEP_W-1:0]      r_step;

    // pending result
    logic                   r_res_det;
    logic [COL_W-1:0]       r_res_col;
    logic [ROW_W-1:0]       r_res_row;
    logic [CNT_W-1:0]       r_res_cnt;

    // output register
    logic                   r_out_valid;
    logic                   r_out_det;
    logic [COL_W-1:0]       r_out_col;
    logic [ROW_W-1:0]       r_out_row;
    logic [CNT_W-1:0]       r_out_cnt;

    logic                   in_fire;
    logic                   cfg_wr;
    mbcd_pkg::t_reg_idx     cfg_idx;
    logic                   px_hit;
    logic [CNT_W:0]         cnt_inc;
    logic [SUM_W:0]         col_add;
    logic [SUM_W:0]         row_add;
    logic [CNT_W-1:0]       n_cnt;
    logic [SUM_W-1:0]       n_col_sum;
    logic [SUM_W-1:0]       n_row_sum;
    logic                   frame_det;
    logic [CNT_W:0]         rem_sh;
    logic                   div_ge;
    logic [CNT_W-1:0]       n_rem;
    logic [SUM_W-1:0]       n_quo;
    logic                   div_last;
    logic                   out_free;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // ---- accumulate with saturation ----
    assign px_hit  = i_foreground && (i_row > r_start_row);
    assign cnt_inc = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign col_add = {1'b0, r_col_sum} + (SUM_W+1)'(i_col);
    assign row_add = {1'b0, r_row_sum} + (SUM_W+1)'(i_row);

    always_comb begin
        n_cnt     = r_cnt;
        n_col_sum = r_col_sum;
        n_row_sum = r_row_sum;
        if (px_hit) begin
            n_cnt     = cnt_inc[CNT_W] ? {CNT_W{1'b1}} : cnt_inc[CNT_W-1:0];
            n_col_sum = col_add[SUM_W] ? {SUM_W{1'b1}} : col_add[SUM_W-1:0];
            n_row_sum = row_add[SUM_W] ? {SUM_W{1'b1}} : row_add[SUM_W-1:0];
        end
    end

    assign frame_det = (n_cnt > r_count_low) && (n_cnt < r_count_high)
                       && (n_cnt != '0);

    // ---- shared restoring divider, one quotient bit a cycle ----
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, r_div};
    assign n_rem    = div_ge ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
    assign n_quo    = {r_quo[SUM_W-2:0], div_ge};
    assign div_last = (r_step == STEP_W'(SUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_col_sum   <= '0;
            r_row_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, else drop the one just taken
            if (r_state == S_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_frame_end) begin
                            r_cnt     <= '0;
                            r_col_sum <= '0;
                            r_row_sum <= '0;
                            r_state   <= frame_det ? S_DIV_COL : S_LOAD;
                        end else begin
                            r_cnt     <= n_cnt;
                            r_col_sum <= n_col_sum;
                            r_row_sum <= n_row_sum;
                        end
                    end
                end
                S_DIV_COL: begin
                    if (div_last) begin
                        r_state <= S_DIV_ROW;
                    end
                end
                S_DIV_ROW: begin
                    if (div_last) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload and divider datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_frame_end) begin
                    r_res_det <= frame_det;
                    r_res_cnt <= n_cnt;
                    r_res_col <= '0;
                    r_res_row <= '0;
                    r_div     <= n_cnt;
                    r_rem     <= '0;
                    r_quo     <= n_col_sum;
                    r_row_dvd <= n_row_sum;
                    r_step    <= '0;
                end
            end
            S_DIV_COL: begin
                if (div_last) begin
                    // hand the divider over to the row sum
                    r_res_col <= n_quo[COL_W-1:0];
                    r_rem     <= '0;
                    r_quo     <= r_row_dvd;
                    r_step    <= '0;
                end else begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + STEP_W'(1);
                end
            end
            S_DIV_ROW: begin
                if (div_last) begin
                    r_res_row <= n_quo[ROW_W-1:0];
                end else begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + STEP_W'(1);
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    r_out_det <= r_res_det;
                    r_out_col <= r_res_col;
                    r_out_row <= r_res_row;
                    r_out_cnt <= r_res_cnt;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_detected     = r_out_det;
    assign o_centroid_col = r_out_col;
    assign o_centroid_row = r_out_row;
    assign o_pixel_count  = r_out_cnt;

    // ---- configuration registers ----
    assign pready  = 1'b1;
    assign cfg_idx = mbcd_pkg::t_reg_idx'(paddr[mbcd_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row  <= ROW_W'(mbcd_pkg::START_ROW_RST);
            r_count_low  <= mbcd_pkg::COUNT_LOW_RST;
            r_count_high <= mbcd_pkg::COUNT_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mbcd_pkg::REG_START_ROW:  r_start_row  <= pwdata[ROW_W-1:0];
                mbcd_pkg::REG_COUNT_LOW:  r_count_low  <= pwdata[CNT_W-1:0];
                mbcd_pkg::REG_COUNT_HIGH: r_count_high <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mbcd_pkg::REG_START_ROW:  prdata = DATA_W'(r_start_row);
            mbcd_pkg::REG_COUNT_LOW:  prdata = DATA_W'(r_count_low);
            mbcd_pkg::REG_COUNT_HIGH: prdata = DATA_W'(r_count_high);
            default:                  prdata = '0;
        endcase
    end

endmodule

[verif/masked_blob_centroid_detect_checker.sv]
// ----------------------------------------------------------------------------
// masked_blob_centroid_detect_checker: centroid prediction and result check
// Snoops the configuration writes and the accepted pixel transfers, folds
// each counted pixel into its own count and coordinate sums, and on every
// frame end queues the expected centroid. Each result transfer is compared
// field by field with the oldest queued centroid.
// ----------------------------------------------------------------------------
module masked_blob_centroid_detect_checker
    import mbcd_pkg::*;
#(
    parameter int COL_W = 10,
    parameter int ROW_W = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [COL_W-1:0]   i_col,
    input  logic [ROW_W-1:0]   i_row,
    input  logic               i_foreground,
    input  logic               i_frame_end,

    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               o_detected,
    input  logic [COL_W-1:0]   o_centroid_col,
    input  logic [ROW_W-1:0]   o_centroid_row,
    input  logic [CNT_W-1:0]   o_pixel_count,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,

    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             detected;
        logic [COL_W-1:0] centroid_col;
        logic [ROW_W-1:0] centroid_row;
        logic [CNT_W-1:0] pixel_count;
    } t_centroid;

    logic [ROW_W-1:0] row_floor;
    logic [CNT_W-1:0] lower_limit;
    logic [CNT_W-1:0] upper_limit;

    logic [CNT_W-1:0] counted;
    logic [SUM_W-1:0] col_total;
    logic [SUM_W-1:0] row_total;

    t_centroid        awaited_centroids[$];
    int               errors = 0;

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] acc,
                                                 input logic [SUM_W-1:0] add);
        logic [SUM_W:0] wide;
        wide = {1'b0, acc} + {1'b0, add};
        return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    endfunction

    // fold one pixel into the frame totals; returns 1 with the centroid on a frame end
    function automatic bit accumulate_pixel(input logic [COL_W-1:0] c,
                                            input logic [ROW_W-1:0] r,
                                            input logic fg,
                                            input logic fe,
                                            output t_centroid res);
        logic [SUM_W-1:0] mean_col;
        logic [SUM_W-1:0] mean_row;
        res = '0;
        if (fg && r > row_floor) begin
            if (counted != {CNT_W{1'b1}})
                counted = counted + CNT_W'(1);
            col_total = sum_sat(col_total, SUM_W'(c));
            row_total = sum_sat(row_total, SUM_W'(r));
        end
        if (!fe)
            return 1'b0;
        res.pixel_count = counted;
        if (counted > lower_limit && counted < upper_limit && counted != '0) begin
            mean_col           = col_total / SUM_W'(counted);
            mean_row           = row_total / SUM_W'(counted);
            res.detected       = 1'b1;
            res.centroid_col   = mean_col[COL_W-1:0];
            res.centroid_row   = mean_row[ROW_W-1:0];
        end
        counted   = '0;
        col_total = '0;
        row_total = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_centroid want;
        if (!i_rst_n) begin
            row_floor   = ROW_W'(START_ROW_RST);
            lower_limit = COUNT_LOW_RST;
            upper_limit = COUNT_HIGH_RST;
            counted     = '0;
            col_total   = '0;
            row_total   = '0;
            awaited_centroids.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[IDX_W+1:2]))
                    REG_START_ROW:  row_floor   = pwdata[ROW_W-1:0];
                    REG_COUNT_LOW:  lower_limit = pwdata[CNT_W-1:0];
                    REG_COUNT_HIGH: upper_limit = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall) begin
                if (awaited_centroids.size() == 0) begin
                    $display("%0t: result with no frame end outstanding: detected %0d",
                             $time, o_detected);
                    $display("%0t:   col %0d row %0d count %0d", $time,
                             o_centroid_col, o_centroid_row, o_pixel_count);
                    errors++;
                end else begin
                    want = awaited_centroids.pop_front();
                    check_field("detected", 32'(want.detected), 32'(o_detected));
                    check_field("centroid_col", 32'(want.centroid_col),
                                32'(o_centroid_col));
                    check_field("centroid_row", 32'(want.centroid_row),
                                32'(o_centroid_row));
                    check_field("pixel_count", 32'(want.pixel_count),
                                32'(o_pixel_count));
                end
            end

            if (i_in_valid && !o_in_stall) begin
                if (accumulate_pixel(i_col, i_row, i_foreground, i_frame_end, want))
                    awaited_centroids.push_back(want);
            end
        end
        o_pending <= awaited_centroids.size();
        o_errors  <= errors;
    end

endmodule

[verif/masked_blob_centroid_detect_test.sv]
// ----------------------------------------------------------------------------
// masked_blob_centroid_detect_test: top of the centroid detector testbench
// Drives pixel frames in random bursts, a stalling result side with one long
// hold-off, and register settings across phases including the extremes. A
// checker beside the block predicts every centroid and counts mismatches.
// ----------------------------------------------------------------------------
module masked_blob_centroid_detect_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mbcd_pkg::*;

    localparam int COL_W          = $clog2(FRAME_WIDTH_DEF);
    localparam int ROW_W          = $clog2(FRAME_HEIGHT_DEF);
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_PIXELS   = 175;
    localparam int CYCLE_LIMIT    = 600000;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} t_stall_style;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [COL_W-1:0]   i_col        = '0;
    logic [ROW_W-1:0]   i_row        = '0;
    logic               i_foreground = 1'b0;
    logic               i_frame_end  = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic               o_detected;
    logic [COL_W-1:0]   o_centroid_col;
    logic [ROW_W-1:0]   o_centroid_row;
    logic [CNT_W-1:0]   o_pixel_count;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [ADDR_W-1:0]  paddr        = '0;
    logic [DATA_W-1:0]  pwdata       = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 pending;
    int                 errors;
    int                 burst_left   = 0;
    int                 gap_max      = 0;
    bit                 hold_req     = 1'b0;
    bit                 hold_done    = 1'b0;

    masked_blob_centroid_detect dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_foreground   (i_foreground),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_detected     (o_detected),
        .o_centroid_col (o_centroid_col),
        .o_centroid_row (o_centroid_row),
        .o_pixel_count  (o_pixel_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    masked_blob_centroid_detect_checker #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_foreground   (i_foreground),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_detected     (o_detected),
        .o_centroid_col (o_centroid_col),
        .o_centroid_row (o_centroid_row),
        .o_pixel_count  (o_pixel_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // setup phase, access phase, then back to idle
    task automatic reg_write(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // fill the bits above the register width with noise
    function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] v, input int w);
        return (DATA_W'($urandom) << w) | v;
    endfunction

    task automatic set_limits(input logic [ROW_W-1:0] first_row,
                              input logic [CNT_W-1:0] lo,
                              input logic [CNT_W-1:0] hi);
        reg_write(REG_START_ROW, with_junk(DATA_W'(first_row), ROW_W));
        reg_write(REG_COUNT_LOW, with_junk(DATA_W'(lo), CNT_W));
        reg_write(REG_COUNT_HIGH, with_junk(DATA_W'(hi), CNT_W));
    endtask

    // one pixel transfer; open a gap first when the current burst is spent and gap_max is not zero
    task automatic offer_pixel(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                               input logic fg, input logic fe);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if (gap_max != 0)
                gap = $urandom_range(1, gap_max);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_col        <= c;
        i_row        <= r;
        i_foreground <= fg;
        i_frame_end  <= fe;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic drain_and_settle;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stream_frames(input int pixels, input int longest);
        int left;
        int len;
        int fg_pct;
        left = pixels;
        while (left > 0) begin
            len = $urandom_range(1, longest);
            if (len > left)
                len = left;
            case ($urandom_range(0, 3))
                0:       fg_pct = 0;
                1:       fg_pct = 30;
                2:       fg_pct = 75;
                default: fg_pct = 100;
            endcase
            for (int k = 0; k < len; k++)
                offer_pixel(COL_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 511)),
                            $urandom_range(0, 99) < fg_pct, k == len - 1);
            left -= len;
        end
    endtask

    // result side: stall in random styles; one long hold-off on request
    initial begin
        t_stall_style style;
        int seg;
        forever begin
            if (hold_req && !hold_done) begin
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_done = 1'b1;
            end
            style = t_stall_style'($urandom_range(0, 3));
            seg   = $urandom_range(20, 200);
            repeat (seg) begin
                @(posedge i_clk);
                case (style)
                    FLOW:    i_out_stall <= 1'b0;
                    LIGHT:   i_out_stall <= ($urandom_range(0, 3) == 0);
                    HEAVY:   i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
                if (hold_req && !hold_done)
                    break;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [CNT_W-1:0] lo;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_max = 3;

        // reset settings: row at start_row is dropped, nothing reaches the low limit
        offer_pixel(5, 100, 1'b1, 1'b1);
        offer_pixel(0, 240, 1'b1, 1'b0);
        offer_pixel(1023, 511, 1'b1, 1'b0);
        offer_pixel(640, 241, 1'b0, 1'b1);
        drain_and_settle();

        // narrow window: counts 1 and 4 sit on the limits, 2 and 3 detect
        set_limits(0, 1, 4);
        reg_write(REG_NONE, DATA_W'($urandom));
        offer_pixel(0, 1, 1'b1, 1'b1);
        offer_pixel(1023, 511, 1'b1, 1'b0);
        offer_pixel(0, 0, 1'b1, 1'b0);
        offer_pixel(1022, 510, 1'b1, 1'b1);
        offer_pixel(1, 1, 1'b1, 1'b0);
        offer_pixel(2, 2, 1'b1, 1'b0);
        offer_pixel(4, 4, 1'b1, 1'b1);
        for (int k = 0; k < 4; k++)
            offer_pixel(COL_W'(k * 300), ROW_W'(k * 100 + 7), 1'b1, k == 3);
        drain_and_settle();

        // start row at its top: no row can lie above it
        set_limits(ROW_W'(511), 0, COUNT_MAX);
        offer_pixel(1023, 511, 1'b1, 1'b1);
        drain_and_settle();

        for (int p = 0; p < 8; p++) begin
            lo = CNT_W'($urandom_range(0, 8));
            case (p)
                0: begin
                    set_limits(ROW_W'($urandom_range(0, 479)), lo,
                               lo + CNT_W'($urandom_range(2, 30)));
                    gap_max = 8;
                end
                1: begin
                    set_limits(0, 0, COUNT_MAX);
                    gap_max = 0;
                end
                2: begin
                    set_limits(ROW_W'(511), 0, COUNT_MAX);
                    gap_max = 3;
                end
                3: begin
                    set_limits(ROW_W'($urandom_range(0, 479)), COUNT_MAX, COUNT_MAX);
                    gap_max = 5;
                end
                4: begin
                    set_limits(ROW_W'($urandom_range(0, 100)), 20, 3);
                    gap_max = 2;
                end
                5: begin
                    // hold the result side while pixels keep coming
                    set_limits(ROW_W'($urandom_range(0, 100)), 0, COUNT_MAX);
                    gap_max  = 0;
                    hold_req = 1'b1;
                end
                default: begin
                    set_limits(ROW_W'($urandom_range(0, 511)), lo,
                               lo + CNT_W'($urandom_range(1, 30)));
                    gap_max = $urandom_range(0, 6);
                end
            endcase
            stream_frames(PHASE_PIXELS, p == 5 ? 4 : 40);
            drain_and_settle();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/mbcd_pkg.sv
rtl/masked_blob_centroid_detect.sv
verif/masked_blob_centroid_detect_checker.sv
verif/masked_blob_centroid_detect_test.sv
